>>> rtl/rsps_pkg.sv
// Shared types, codes and stripe mapping functions for the RAID-5 parity store.
`timescale 1ns / 1ps
`default_nettype none

package rsps_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned Disks     = 5;
  localparam int unsigned DataDisks = 4;
  localparam int unsigned StripeW   = 4;
  localparam int unsigned PdiskW    = 3;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [Disks-1:0] row_t;
  typedef word_t [DataDisks-1:0] data_t;

  typedef enum logic {
    ActWrite = 1'b0,
    ActRead  = 1'b1
  } action_e;

  // Parity disk for a stripe: 4 - (stripe mod 5).
  function automatic logic [PdiskW-1:0] parity_disk(input logic [StripeW-1:0] s);
    logic [PdiskW-1:0] p;
    unique case (s)
      4'd0, 4'd5, 4'd10, 4'd15: p = 3'd4;
      4'd1, 4'd6, 4'd11:        p = 3'd3;
      4'd2, 4'd7, 4'd12:        p = 3'd2;
      4'd3, 4'd8, 4'd13:        p = 3'd1;
      4'd4, 4'd9, 4'd14:        p = 3'd0;
    endcase
    return p;
  endfunction

  // Lay data words onto disks in ascending order around the parity disk.
  function automatic row_t pack_row(input data_t w, input word_t par,
                                    input logic [PdiskW-1:0] p);
    row_t r;
    for (int k = 0; k < Disks; k++) begin
      if (k == int'(p)) begin
        r[k] = par;
      end else if (k < int'(p)) begin
        r[k] = w[k];
      end else begin
        r[k] = w[k-1];
      end
    end
    return r;
  endfunction

  // Collect data words from a row, skipping the parity disk.
  function automatic data_t unpack_row(input row_t r, input logic [PdiskW-1:0] p);
    data_t d;
    for (int j = 0; j < DataDisks; j++) begin
      d[j] = (j < int'(p)) ? r[j] : r[j+1];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/raid5_stripe_parity_store_core.sv
// Top level of the RAID-5 rotating-parity stripe store.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per stripe
//   operation: action_i selects write (store four words plus XOR parity) or
//   read (return the stored data words and parity). Output channel
//   (out_valid_o / out_stall_i) returns exactly one transaction per input.
//   Each accepted transaction passes the middle stage and then the output
//   register before the receiver can take its result.
//   Throughput: one transaction per cycle while the output is not stalled; the
//   stripe memory has one port, a write at the accept edge and a registered
//   read, so a read right after a write of the same stripe already sees it.
//   Reset: after rst_ni releases, a clearing sweep writes all ones into every
//   stripe row, one row per cycle; in_stall_o is high for that time.
//   Stall: when out_stall_i holds a result, one more transaction may be taken
//   into the middle stage; after that in_stall_o rises until the output moves.
//   Stripe indexes of STRIPES or more wrap modulo STRIPES when STRIPES is 4 or more.
module raid5_stripe_parity_store_core #(
  parameter int unsigned STRIPES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [3:0]  stripe_i,
  input  wire logic [63:0] word_a_i,
  input  wire logic [63:0] word_b_i,
  input  wire logic [63:0] word_c_i,
  input  wire logic [63:0] word_d_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_a_o,
  output logic [63:0]      out_b_o,
  output logic [63:0]      out_c_o,
  output logic [63:0]      out_d_o,
  output logic [63:0]      parity_word_o,
  output logic [2:0]       parity_disk_o
);

  localparam int unsigned AW = $clog2(STRIPES);

  logic                             accept;
  logic                             clearing;
  logic [4:0]                       wrap_v;
  logic [AW-1:0]                    addr;
  logic [rsps_pkg::PdiskW-1:0]      pdisk;
  rsps_pkg::data_t                  in_data;
  rsps_pkg::word_t                  in_par;
  rsps_pkg::row_t                   wr_row;
  rsps_pkg::row_t                   rd_row;

  // Middle stage: item whose memory access is done.
  logic                             s1_valid_q, s1_valid_d;
  logic                             s1_read_q;
  logic [rsps_pkg::PdiskW-1:0]      s1_pdisk_q;
  rsps_pkg::data_t                  s1_data_q;
  rsps_pkg::word_t                  s1_par_q;
  logic                             s1_go;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  rsps_pkg::data_t                  out_data_q;
  rsps_pkg::word_t                  out_par_q;
  logic [rsps_pkg::PdiskW-1:0]      out_pdisk_q;

  // Wrap the stripe index into the store; at most three subtractions.
  always_comb begin
    wrap_v = {1'b0, stripe_i};
    if (STRIPES < 16) begin
      for (int i = 0; i < 3; i++) begin
        if (wrap_v >= 5'(STRIPES)) begin
          wrap_v = wrap_v - 5'(STRIPES);
        end
      end
    end
  end

  assign addr    = AW'(wrap_v);
  assign pdisk   = rsps_pkg::parity_disk(wrap_v[3:0]);
  assign in_data = {word_d_i, word_c_i, word_b_i, word_a_i};
  assign in_par  = word_a_i ^ word_b_i ^ word_c_i ^ word_d_i;
  assign wr_row  = rsps_pkg::pack_row(in_data, in_par, pdisk);

  // Handshake: advance the middle stage when the output register is free or drains.
  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing || (s1_valid_q && !s1_go);
  assign accept     = in_valid_i && !in_stall_o;

  rsps_disk_mem #(
    .STRIPES (STRIPES),
    .AW      (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && (action_i == rsps_pkg::ActWrite)),
    .rd_en_i    (accept && (action_i == rsps_pkg::ActRead)),
    .addr_i     (addr),
    .wdata_i    (wr_row),
    .rdata_o    (rd_row),
    .clearing_o (clearing)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the item's payload alongside the registered memory read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q  <= (action_i == rsps_pkg::ActRead);
      s1_pdisk_q <= pdisk;
      s1_data_q  <= in_data;
      s1_par_q   <= in_par;
    end
  end

  // Reads pick data and parity from the stored row; writes echo the input.
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_pdisk_q <= s1_pdisk_q;
      if (s1_read_q) begin
        out_data_q <= rsps_pkg::unpack_row(rd_row, s1_pdisk_q);
        out_par_q  <= rd_row[s1_pdisk_q];
      end else begin
        out_data_q <= s1_data_q;
        out_par_q  <= s1_par_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_a_o       = out_data_q[0];
  assign out_b_o       = out_data_q[1];
  assign out_c_o       = out_data_q[2];
  assign out_d_o       = out_data_q[3];
  assign parity_word_o = out_par_q;
  assign parity_disk_o = out_pdisk_q;

  // No item enters while the clearing sweep runs.
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept)
    else $error("item accepted during clearing sweep");

  // An accepted item occupies the middle stage next cycle.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item lost before middle stage");

  // A blocked middle stage holds its item.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go && !accept) |=> (s1_valid_q && $stable(s1_pdisk_q)))
    else $error("middle stage dropped a blocked item");

  // A new result only comes from the middle stage.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a source item");

  // Parity disk is always one of the five disks.
  a_pdisk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pdisk_q <= 3'd4))
    else $error("parity disk out of range");

endmodule

`default_nettype wire

>>> rtl/rsps_disk_mem.sv
// Stripe memory: one row of five disk words per stripe, with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module rsps_disk_mem #(
  parameter int unsigned STRIPES = 16,
  parameter int unsigned AW      = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   addr_i,
  input  wire rsps_pkg::row_t  wdata_i,
  output rsps_pkg::row_t       rdata_o,
  output logic                 clearing_o
);

  rsps_pkg::row_t mem [STRIPES];
  rsps_pkg::row_t rdata_q;
  logic           clr_q, clr_d;
  logic [AW-1:0]  clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(STRIPES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Sweep fills every row with ones; the item port is held off meanwhile.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '1;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the RAID-5 rotating-parity stripe store.
`timescale 1ns / 1ps

module testbench;
  import rsps_pkg::*;

  localparam int unsigned NumStripes    = 16;
  localparam int unsigned RandomItems   = 1350;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned MaxReported   = 10;

  // One result transaction as the block presents it.
  typedef struct packed {
    data_t             data;
    word_t             parity;
    logic [PdiskW-1:0] pdisk;
  } stripe_result_t;

  // Mirror of the five disks plus the queue of results still owed by the block.
  class stripe_parity_board;
    word_t          disk_image [Disks][NumStripes];
    stripe_result_t owed_results [$];
    int unsigned    failures;

    function new();
      foreach (disk_image[d, s]) disk_image[d][s] = '1;
      failures = 0;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= MaxReported) $display("%s", what);
    endfunction

    // Apply an accepted stripe operation to the disk mirror and queue its result.
    function void log_stripe_op(action_e act, logic [StripeW-1:0] stripe, data_t words);
      int unsigned    row;
      int unsigned    pd;
      int unsigned    k;
      stripe_result_t res;
      row       = int'(stripe) % NumStripes;
      pd        = DataDisks - (row % Disks);
      res.pdisk = pd[PdiskW-1:0];
      k         = 0;
      if (act == ActWrite) begin
        res.data   = words;
        res.parity = words[0] ^ words[1] ^ words[2] ^ words[3];
        for (int d = 0; d < Disks; d++) begin
          if (d == int'(pd)) begin
            disk_image[d][row] = res.parity;
          end else begin
            disk_image[d][row] = words[k];
            k++;
          end
        end
      end else begin
        res.parity = disk_image[pd][row];
        for (int d = 0; d < Disks; d++) begin
          if (d != int'(pd)) begin
            res.data[k] = disk_image[d][row];
            k++;
          end
        end
      end
      owed_results.push_back(res);
    endfunction

    // Compare one accepted result against the oldest owed result.
    function void check_stripe_result(stripe_result_t got);
      stripe_result_t want;
      if (owed_results.size() == 0) begin
        flag("stripe store: result transaction with none outstanding");
        return;
      end
      want = owed_results.pop_front();
      for (int j = 0; j < DataDisks; j++) begin
        if (got.data[j] !== want.data[j]) begin
          flag($sformatf("stripe store: data word %0d expected %h, got %h",
                         j, want.data[j], got.data[j]));
        end
      end
      if (got.parity !== want.parity) begin
        flag($sformatf("stripe store: parity_word expected %h, got %h",
                       want.parity, got.parity));
      end
      if (got.pdisk !== want.pdisk) begin
        flag($sformatf("stripe store: parity_disk expected %0d, got %0d",
                       want.pdisk, got.pdisk));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = ActWrite;
  logic [3:0]  stripe_i = '0;
  logic [63:0] word_a_i = '0;
  logic [63:0] word_b_i = '0;
  logic [63:0] word_c_i = '0;
  logic [63:0] word_d_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_a_o;
  logic [63:0] out_b_o;
  logic [63:0] out_c_o;
  logic [63:0] out_d_o;
  logic [63:0] parity_word_o;
  logic [2:0]  parity_disk_o;

  stripe_parity_board parity_board = new();

  // Idle controls shared between the stimulus and the result sink.
  bit          feed_idle_en  = 1'b1;
  bit          drain_idle_en = 1'b1;
  int unsigned long_hold_req = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  raid5_stripe_parity_store_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .stripe_i     (stripe_i),
    .word_a_i     (word_a_i),
    .word_b_i     (word_b_i),
    .word_c_i     (word_c_i),
    .word_d_i     (word_d_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_a_o      (out_a_o),
    .out_b_o      (out_b_o),
    .out_c_o      (out_c_o),
    .out_d_o      (out_d_o),
    .parity_word_o(parity_word_o),
    .parity_disk_o(parity_disk_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bias data words toward the corners: zero, all ones, a single set bit.
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = word_t'(1) << $urandom_range(0, 63);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Offer one transaction after a random gap and hold it until accepted. Valid
  // stays high on return, so the next call either reloads it or drops it.
  task automatic send_item(input action_e act, input logic [3:0] stripe,
                           input word_t a, input word_t b, input word_t c, input word_t d);
    int unsigned gap;
    data_t       words;
    gap = feed_idle_en ? $urandom_range(0, 3) : 0;
    words = {d, c, b, a};
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    stripe_i   <= stripe;
    word_a_i   <= a;
    word_b_i   <= b;
    word_c_i   <= c;
    word_d_i   <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parity_board.log_stripe_op(act, stripe, words);
    items_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (parity_board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Result sink: stall a random number of cycles before each transaction,
  // or for a long stretch when asked, then take and check the next result.
  initial begin : result_sink
    int unsigned hold;
    stripe_result_t got;
    forever begin
      if (long_hold_req != 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end else begin
        hold = drain_idle_en ? $urandom_range(0, 3) : 0;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.data   = {out_d_o, out_c_o, out_b_o, out_a_o};
      got.parity = parity_word_o;
      got.pdisk  = parity_disk_o;
      parity_board.check_stripe_result(got);
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned  phase_left;
    bit           hold_done;
    bit           pause_done;
    logic [3:0]   s;
    word_t        w;
    phase_left = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // Hold reset, then release it; the clearing sweep afterward shows as input stall.
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Read before any write: every word comes back as all ones, one read per
    // parity disk position plus the top stripe. Data words on read are ignored.
    send_item(ActRead, 4'd0, '1, '1, '1, '1);
    send_item(ActRead, 4'd1, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd2, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd3, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd4, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd15, pick_word(), pick_word(), pick_word(), pick_word());

    // Writes at the word extremes, each parity disk position, then read back.
    send_item(ActWrite, 4'd0, '0, '0, '0, '0);
    send_item(ActRead, 4'd0, '1, '1, '1, '1);
    send_item(ActWrite, 4'd1, '1, '1, '1, '1);
    send_item(ActWrite, 4'd2, '1, '0, '1, '0);
    send_item(ActWrite, 4'd3, 64'h1, 64'h2, 64'h4, 64'h8000_0000_0000_0000);
    send_item(ActWrite, 4'd4, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
              64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF);
    send_item(ActRead, 4'd1, '0, '0, '0, '0);
    send_item(ActRead, 4'd2, '0, '0, '0, '0);
    send_item(ActRead, 4'd3, '0, '0, '0, '0);
    send_item(ActRead, 4'd4, '0, '0, '0, '0);
    send_item(ActWrite, 4'd15, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd15, pick_word(), pick_word(), pick_word(), pick_word());
    // Overwrite the same stripe back to back, then read.
    send_item(ActWrite, 4'd7, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActWrite, 4'd7, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ActRead, 4'd7, pick_word(), pick_word(), pick_word(), pick_word());
    drain_results();

    // Random part: single operations mixed with write-then-read pairs on one
    // stripe, in phases with and without idling on either side.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      if (phase_left == 0) begin
        phase_left    = $urandom_range(40, 160);
        feed_idle_en  = $urandom_range(0, 2) != 0;
        drain_idle_en = $urandom_range(0, 2) != 0;
      end
      if (!hold_done && items_sent >= 400) begin
        // Stall the output long enough for the pipeline to back up to the input.
        long_hold_req = LongHold;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= 800) begin
        drain_results();
        pause_done = 1'b1;
      end
      s = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 35) begin
        send_item(ActWrite, s, pick_word(), pick_word(), pick_word(), pick_word());
        send_item(ActRead, s, pick_word(), pick_word(), pick_word(), pick_word());
        phase_left = (phase_left > 2) ? phase_left - 2 : 0;
      end else begin
        w = pick_word();
        send_item($urandom_range(0, 1) ? ActRead : ActWrite, s,
                  w, pick_word(), pick_word(), pick_word());
        phase_left--;
      end
    end

    // Drain, then let the pipeline settle so that any stray result shows up.
    drain_results();
    repeat (8) @(posedge clk_i);
    if (parity_board.failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
